FILE: sv/csk_pkg.sv
// Shared constants, codes, types and index function for the count-min sketch.
package csk_pkg;

    localparam int COUNTERS  = 4096;
    localparam int ROWS      = 4;
    localparam int WORDS     = COUNTERS / 8;
    localparam int IDX_W     = $clog2(COUNTERS);
    localparam int WORD_AW   = (IDX_W > 3) ? IDX_W - 3 : 1;
    localparam int CNT_W     = $clog2(WORDS + 1);
    localparam int MASK_W    = 12;
    localparam int SEED_W    = 32;
    localparam int HASH_W    = 32;
    localparam int FUNC_W    = 2;
    localparam int EST_W     = 4;
    localparam int CFG_IDX_W = 3;
    localparam int DATA_W    = 32;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_ESTIMATE  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_INCREMENT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DECAY     = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR     = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SEED0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEED1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEED2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SEED3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MASK  = 3'd4;

    localparam logic [MASK_W-1:0] MASK_RESET = 12'hFFF;
    localparam logic [DATA_W-1:0] DECAY_KEEP = 32'h7777_7777;
    localparam logic [EST_W-1:0]  CNT_MAX    = 4'd15;

    // Per-cycle command from the sequencer to every row
    typedef struct packed {
        logic               lookup;
        logic [HASH_W-1:0]  key_hash;
        logic               bump;
        logic               sweep_rd;
        logic               sweep_wr;
        logic               decay;
        logic [WORD_AW-1:0] sweep_rd_addr;
        logic [WORD_AW-1:0] sweep_wr_addr;
    } row_cmd_t;

    // Counter index of a key in one row
    function automatic logic [IDX_W-1:0] sk_index(
        input logic [HASH_W-1:0] hash,
        input logic [SEED_W-1:0] seed,
        input logic [MASK_W-1:0] mask
    );
        logic [31:0] full;
        full = (hash ^ seed) & {{(32 - MASK_W){1'b0}}, mask} & 32'(COUNTERS - 1);
        return full[IDX_W-1:0];
    endfunction

endpackage

FILE: sv/count_min_sketch_4bit.sv
// Count-min sketch top level: sequencer, configuration registers, rows and result register.
// Four rows of 4-bit counters, each row a 512 x 32 memory with a registered read.
// Estimate and increment read the memory word, then compare or increment and write back;
// a new item is taken only once the sequencer is back in idle and the result can be taken.
// Decay and clear sweep all 512 words of all rows in parallel, one word read and one word
// written per cycle. After reset a clearing pass runs with in_ready low; configuration writes
// are taken at any time (cfg_ready is always high). The result register holds one finished
// result, and a new item is accepted in the cycle the old one is taken.
module count_min_sketch_4bit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [csk_pkg::FUNC_W-1:0]    func,
    input  logic [csk_pkg::HASH_W-1:0]    key_hash,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [csk_pkg::EST_W-1:0]     estimate,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [csk_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [csk_pkg::DATA_W-1:0]    cfg_data
);
    import csk_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SWEEP
    } state_t;

    state_t             state_reg, state_next;
    logic [FUNC_W-1:0]  op_reg, op_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               report_reg, report_next;
    logic               out_valid_reg, out_valid_next;
    logic [EST_W-1:0]   estimate_reg, estimate_next;

    logic [SEED_W-1:0]  seed_reg [ROWS];
    logic [MASK_W-1:0]  mask_reg;

    logic               accept;
    logic               sweep_done;
    logic [EST_W-1:0]   row_count [ROWS];
    logic [EST_W-1:0]   min_count;
    row_cmd_t           cmd;

    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign estimate   = estimate_reg;
    assign in_ready   = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept     = in_valid && in_ready;
    assign sweep_done = (cnt_reg == CNT_W'(WORDS));

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ROWS; i++)
            begin
                seed_reg[i] <= '0;
            end
            mask_reg <= MASK_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SEED0: seed_reg[0] <= cfg_data;
                REG_SEED1: seed_reg[1] <= cfg_data;
                REG_SEED2: seed_reg[2] <= cfg_data;
                REG_SEED3: seed_reg[3] <= cfg_data;
                REG_MASK:  mask_reg    <= cfg_data[MASK_W-1:0];
                default:   ;
            endcase
        end
    end

    // Drive the per-cycle row command
    always_comb
    begin
        cmd               = '0;
        cmd.key_hash      = key_hash;
        cmd.lookup        = accept && (func == FUNC_ESTIMATE || func == FUNC_INCREMENT);
        cmd.bump          = (state_reg == ST_LOOKUP) && (op_reg == FUNC_INCREMENT);
        cmd.sweep_rd      = (state_reg == ST_SWEEP) && !sweep_done;
        cmd.sweep_wr      = (state_reg == ST_SWEEP) && (cnt_reg != '0);
        cmd.decay         = (op_reg == FUNC_DECAY);
        cmd.sweep_rd_addr = WORD_AW'(cnt_reg);
        cmd.sweep_wr_addr = WORD_AW'(cnt_reg - CNT_W'(1));
    end

    // Sketch rows
    for (genvar r = 0; r < ROWS; r++)
    begin : g_row
        csk_row u_row (
            .clk   (clk),
            .cmd   (cmd),
            .seed  (seed_reg[r]),
            .mask  (mask_reg),
            .count (row_count[r])
        );
    end

    // Minimum over the rows
    always_comb
    begin
        min_count = row_count[0];
        for (int i = 1; i < ROWS; i++)
        begin
            if (row_count[i] < min_count)
            begin
                min_count = row_count[i];
            end
        end
    end

    // Sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        cnt_next       = cnt_reg;
        report_next    = report_reg;
        estimate_next  = estimate_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next = func;
                    unique case (func) inside
                        FUNC_ESTIMATE, FUNC_INCREMENT:
                        begin
                            state_next = ST_LOOKUP;
                        end
                        default:
                        begin
                            state_next  = ST_SWEEP;
                            cnt_next    = '0;
                            report_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_LOOKUP:
            begin
                out_valid_next = 1'b1;
                estimate_next  = (op_reg == FUNC_ESTIMATE) ? min_count : '0;
                state_next     = ST_IDLE;
            end
            ST_SWEEP:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (sweep_done)
                begin
                    state_next = ST_IDLE;
                    if (report_reg)
                    begin
                        out_valid_next = 1'b1;
                        estimate_next  = '0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer state and result register; reset starts the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            op_reg        <= FUNC_CLEAR;
            cnt_reg       <= '0;
            report_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            estimate_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            cnt_reg       <= cnt_next;
            report_reg    <= report_next;
            out_valid_reg <= out_valid_next;
            estimate_reg  <= estimate_next;
        end
    end

endmodule

FILE: sv/csk_row.sv
// One sketch row: word memory, index registers and read-modify-write datapath.
module csk_row (
    input  logic                    clk,
    input  csk_pkg::row_cmd_t       cmd,
    input  logic [csk_pkg::SEED_W-1:0] seed,
    input  logic [csk_pkg::MASK_W-1:0] mask,
    output logic [csk_pkg::EST_W-1:0]  count
);
    import csk_pkg::*;

    logic [DATA_W-1:0]  mem [WORDS];
    logic [DATA_W-1:0]  rd_data_reg;
    logic [WORD_AW-1:0] addr_reg;
    logic [2:0]         sel_reg;
    logic               hit_reg;

    logic [IDX_W-1:0]   idx;
    logic [WORD_AW-1:0] idx_addr;
    logic               idx_hit;
    logic               rd_en;
    logic [WORD_AW-1:0] rd_addr;
    logic               wr_en;
    logic [WORD_AW-1:0] wr_addr;
    logic [DATA_W-1:0]  wr_data;
    logic [4:0]         sh;
    logic [EST_W-1:0]   nib;
    logic [DATA_W-1:0]  bumped;

    // Locate the counter of the incoming key
    always_comb
    begin
        idx      = sk_index(cmd.key_hash, seed, mask);
        idx_addr = WORD_AW'(idx >> 3);
        idx_hit  = (32'(idx) >> 3) < 32'(WORDS);
    end

    // Hold the location for the modify cycle
    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            addr_reg <= idx_addr;
            sel_reg  <= idx[2:0];
            hit_reg  <= idx_hit;
        end
    end

    // Pick the counter out of the word read back
    always_comb
    begin
        sh     = {sel_reg, 2'b00};
        nib    = EST_W'(rd_data_reg >> sh);
        count  = hit_reg ? nib : '0;
        bumped = rd_data_reg + (DATA_W'(nib != CNT_MAX) << sh);
    end

    // Select memory port addresses and write data
    always_comb
    begin
        rd_en   = cmd.lookup | cmd.sweep_rd;
        rd_addr = cmd.lookup ? idx_addr : cmd.sweep_rd_addr;
        wr_en   = (cmd.bump & hit_reg) | cmd.sweep_wr;
        wr_addr = cmd.bump ? addr_reg : cmd.sweep_wr_addr;
        if (cmd.bump)
        begin
            wr_data = bumped;
        end
        else if (cmd.decay)
        begin
            wr_data = (rd_data_reg >> 1) & DECAY_KEEP;
        end
        else
        begin
            wr_data = '0;
        end
    end

    // Word memory, one read and one write port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

endmodule

FILE: sv/csk_checker.sv
// Port-level assertions for the count-min sketch, bound to the top level.
module csk_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic [csk_pkg::FUNC_W-1:0]    func,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [csk_pkg::EST_W-1:0]     estimate
);
    import csk_pkg::*;

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(estimate))
        else $error("result changed or dropped while stalled");

    // No request taken while a stalled result occupies the output
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid || out_ready)
        else $error("request taken with output blocked");

    // Output register is empty the cycle after a request is taken
    a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !out_valid)
        else $error("stale result after request");

    // Increment answers zero after its lookup state, during which in_ready is low
    a_inc_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && func == FUNC_INCREMENT
        |=> !in_ready ##1 out_valid && estimate == '0)
        else $error("increment result wrong or late");

endmodule

bind count_min_sketch_4bit csk_checker u_csk_checker (.*);
